// ----- rtl/ukst_pkg.sv -----
`timescale 1ns / 1ps

package ukst_pkg;

   localparam int DEPTH_DEFAULT     = 16;
   localparam int KEY_WIDTH_DEFAULT = 32;

   localparam int REQ_TYPE_W = 2;
   localparam int KEY_PORT_W = 32;
   localparam int STATUS_W   = 2;
   localparam int OCC_W      = 5;

   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_ADD      = 2'd0,
      REQ_REMOVE   = 2'd1,
      REQ_CONTAINS = 2'd2
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_TRUE  = 2'd0,
      ST_FALSE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

endpackage

// ----- rtl/unordered_key_set_table_unit.sv -----
`timescale 1ns / 1ps
// Add, contains and remove search the held entries in order from the accepted request beat; a
// remove that hits an entry before the last held one then moves the later entries down. An
// unused request kind goes straight to the result with a false status. A result beat held
// back by the consumer keeps the next result waiting in S_FIN. One request is worked at a
// time, so a new request is taken once the last result is registered.
// Reset clears the entry count, the state and the valid flags; the key store is not cleared.
module unordered_key_set_table_unit #(
   parameter int DEPTH     = ukst_pkg::DEPTH_DEFAULT,
   parameter int KEY_WIDTH = ukst_pkg::KEY_WIDTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [ukst_pkg::REQ_TYPE_W-1:0] req_type,
   input  logic [ukst_pkg::KEY_PORT_W-1:0] req_key,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [ukst_pkg::STATUS_W-1:0]   rsp_status,
   output logic [ukst_pkg::OCC_W-1:0]      rsp_occupancy
);

   import ukst_pkg::*;

   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int EXT_W   = (KEY_WIDTH > KEY_PORT_W) ? KEY_WIDTH : KEY_PORT_W;
   localparam int OCC_X_W = (CNT_W > OCC_W) ? CNT_W : OCC_W;
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT,
      S_FIN
   } state_type;

   state_type              state_ff;
   logic [REQ_TYPE_W-1:0]  kind_ff;
   logic [KEY_WIDTH-1:0]   key_ff;
   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       rd_idx_ff;
   logic [CNT_W-1:0]       cmp_idx_ff;
   logic                   cmp_vld_ff;
   logic [CNT_W-1:0]       sh_rd_ff;
   logic [IDX_W-1:0]       sh_wr_ff;
   logic                   sh_vld_ff;
   status_type             status_ff;
   logic                   rsp_valid_ff;
   logic [STATUS_W-1:0]    rsp_status_ff;
   logic [OCC_W-1:0]       rsp_occ_ff;

   logic [EXT_W-1:0]       key_ext;
   logic [KEY_WIDTH-1:0]   key_in;
   logic [CNT_W-1:0]       cnt_m1;
   logic [CNT_W-1:0]       cnt_m2;
   logic [OCC_X_W-1:0]     occ_ext;
   logic                   rd_en;
   logic [IDX_W-1:0]       rd_addr;
   logic [KEY_WIDTH-1:0]   rd_data;
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   logic [KEY_WIDTH-1:0]   wr_data;
   logic                   hit;
   logic                   miss;
   logic                   scan_issue;
   logic                   shift_issue;
   logic                   shift_last;
   logic                   add_ok;

   assign key_ext = EXT_W'(req_key);
   assign key_in  = key_ext[KEY_WIDTH-1:0];
   assign cnt_m1  = count_ff - CNT_W'(1);
   assign cnt_m2  = count_ff - CNT_W'(2);
   assign occ_ext = OCC_X_W'(count_ff);

   assign req_ready     = (state_ff == S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_occupancy = rsp_occ_ff;

   always_comb begin
      scan_issue  = (state_ff == S_SCAN) && (rd_idx_ff < count_ff);
      shift_issue = (state_ff == S_SHIFT) && (sh_rd_ff < count_ff);
      hit         = (state_ff == S_SCAN) && cmp_vld_ff && (rd_data == key_ff);
      // no match once the last held entry has been compared, or nothing is held
      miss        = (state_ff == S_SCAN) && !hit &&
                    ((count_ff == '0) || (cmp_vld_ff && (cmp_idx_ff == cnt_m1)));
      shift_last  = (state_ff == S_SHIFT) && sh_vld_ff && (CNT_W'(sh_wr_ff) == cnt_m2);
      add_ok      = miss && (kind_ff == REQ_ADD) && (count_ff < FULL_COUNT);

      rd_en   = scan_issue || shift_issue;
      rd_addr = (state_ff == S_SHIFT) ? sh_rd_ff[IDX_W-1:0] : rd_idx_ff[IDX_W-1:0];

      wr_en   = add_ok || ((state_ff == S_SHIFT) && sh_vld_ff);
      wr_addr = add_ok ? count_ff[IDX_W-1:0] : sh_wr_ff;
      wr_data = add_ok ? key_ff : rd_data;
   end

   ukst_ram #(
      .DEPTH     (DEPTH),
      .KEY_WIDTH (KEY_WIDTH)
   ) u_ram (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         cmp_vld_ff   <= 1'b0;
         sh_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_ready && (state_ff != S_FIN)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  kind_ff    <= req_type;
                  key_ff     <= key_in;
                  rd_idx_ff  <= '0;
                  cmp_vld_ff <= 1'b0;
                  if (req_type == REQ_ADD || req_type == REQ_REMOVE ||
                      req_type == REQ_CONTAINS) begin
                     state_ff <= S_SCAN;
                  end else begin
                     status_ff <= ST_FALSE;
                     state_ff  <= S_FIN;
                  end
               end
            end
            S_SCAN: begin
               // one read issued and one entry compared per cycle
               cmp_vld_ff <= scan_issue && !hit && !miss;
               cmp_idx_ff <= rd_idx_ff;
               if (scan_issue) begin
                  rd_idx_ff <= rd_idx_ff + CNT_W'(1);
               end
               if (hit) begin
                  if (kind_ff == REQ_REMOVE) begin
                     status_ff <= ST_TRUE;
                     if (cmp_idx_ff == cnt_m1) begin
                        count_ff <= cnt_m1;
                        state_ff <= S_FIN;
                     end else begin
                        sh_rd_ff  <= cmp_idx_ff + CNT_W'(1);
                        sh_vld_ff <= 1'b0;
                        state_ff  <= S_SHIFT;
                     end
                  end else if (kind_ff == REQ_ADD) begin
                     status_ff <= ST_FALSE;
                     state_ff  <= S_FIN;
                  end else begin
                     status_ff <= ST_TRUE;
                     state_ff  <= S_FIN;
                  end
               end else if (miss) begin
                  state_ff   <= S_FIN;
                  if (kind_ff == REQ_ADD) begin
                     if (add_ok) begin
                        status_ff <= ST_TRUE;
                        count_ff  <= count_ff + CNT_W'(1);
                     end else begin
                        status_ff <= ST_FULL;
                     end
                  end else begin
                     status_ff <= ST_FALSE;
                  end
               end
            end
            S_SHIFT: begin
               // read entry j+2 while writing entry j+1, read last cycle, to j
               sh_vld_ff <= shift_issue && !shift_last;
               if (shift_issue) begin
                  sh_wr_ff <= IDX_W'(sh_rd_ff - CNT_W'(1));
                  sh_rd_ff <= sh_rd_ff + CNT_W'(1);
               end
               if (shift_last) begin
                  count_ff  <= cnt_m1;
                  state_ff  <= S_FIN;
               end
            end
            S_FIN: begin
               // hold until the result register is free
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= status_ff;
                  rsp_occ_ff    <= occ_ext[OCC_W-1:0];
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

// ----- rtl/ukst_ram.sv -----
`timescale 1ns / 1ps

module ukst_ram #(
   parameter int DEPTH     = 16,
   parameter int KEY_WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [KEY_WIDTH-1:0]       rd_data,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [KEY_WIDTH-1:0]       wr_data
);

   logic [KEY_WIDTH-1:0] mem [DEPTH];
   logic [KEY_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
